/* rtl/core/command_line_tokenizer_top_assert.svh */
// Assertion macros for the command line tokenizer.
`ifndef COMMAND_LINE_TOKENIZER_TOP_ASSERT_SVH
`define COMMAND_LINE_TOKENIZER_TOP_ASSERT_SVH

// The expression holds at every clock edge outside reset.
`define CLT_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define CLT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/clt_pkg.sv */
// Types, character codes and helpers shared by the command line tokenizer.
`default_nettype none

package clt_pkg;

    typedef enum logic [2:0] {
        PH_START,
        PH_SEEK_KW,
        PH_KEYWORD,
        PH_SEEK_OPT,
        PH_OPTION,
        PH_SEEK_VAL,
        PH_VALUE
    } t_phase;

    typedef enum logic [1:0] {
        END_SEP     = 2'd0,
        END_LINE    = 2'd1,
        END_COMMENT = 2'd2,
        END_NONE    = 2'd3
    } t_end_reason;

    localparam logic KIND_VALUE   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [1:0] CFG_SEPARATOR   = 2'd0;
    localparam logic [1:0] CFG_COMMENT     = 2'd1;
    localparam logic [1:0] CFG_OPTION_SIGN = 2'd2;

    localparam logic [7:0] SEP_RESET     = 8'd59;
    localparam logic [7:0] COMMENT_RESET = 8'd35;
    localparam logic [7:0] OPTION_RESET  = 8'd45;

    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_DOLLAR   = 8'h24;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_0        = 8'h30;
    localparam logic [7:0] CH_9        = 8'h39;
    localparam logic [7:0] CH_UP_A     = 8'h41;
    localparam logic [7:0] CH_UP_F     = 8'h46;
    localparam logic [7:0] CH_UP_X     = 8'h58;
    localparam logic [7:0] CH_LO_A     = 8'h61;
    localparam logic [7:0] CH_LO_F     = 8'h66;
    localparam logic [7:0] CH_LO_X     = 8'h78;
    localparam logic [7:0] CH_PIPE     = 8'h7C;
    localparam logic [7:0] CH_PIPE_SEP = 8'hFF;

    typedef struct packed {
        logic seen2;
        logic x2;
        logic hrun;
        logic hok;
        logic drun;
        logic dok;
        logic dneg;
    } t_tok_status;

    typedef struct packed {
        logic        kind;
        logic [31:0] value;
        logic [3:0]  value_index;
        logic [7:0]  keyword_start;
        logic [7:0]  keyword_len;
        logic [7:0]  option_start;
        logic [7:0]  rest_start;
        logic [4:0]  value_count;
        logic        pipe_mode;
        logic [1:0]  end_reason;
        logic        last;
    } t_result;

    // Returns {valid, digit value}.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= CH_0 && c <= CH_9) begin
            r = {1'b1, c[3:0]};
        end else if (c >= CH_LO_A && c <= CH_LO_F) begin
            r = {1'b1, 4'(c - CH_LO_A) + 4'd10};
        end else if (c >= CH_UP_A && c <= CH_UP_F) begin
            r = {1'b1, 4'(c - CH_UP_A) + 4'd10};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/command_line_tokenizer_top.sv */
// Command line tokenizer: per-character parser with a three-entry result queue.
//
//   Channel   Handshake                   Payload
//   config    i_cfg_we                    i_cfg_index, i_cfg_data
//   input     i_in_valid / o_in_ready     i_ch
//   output    o_out_valid / i_out_ready   o_kind .. o_last
//
// One character is taken per cycle while o_in_ready is high; its results enter the queue at the same edge.
// A character that closes a value token and the command gives two results, which
// leave the queue one at a time, the value result first.
// o_in_ready is high while the result queue holds at most one entry.
// Reset is synchronous; it clears the parse state and loads the register defaults.
`default_nettype none

module command_line_tokenizer_top #(
    parameter int MAX_VALUES  = 16,
    parameter int MAX_CMD_LEN = 256,
    parameter int VALUE_BITS  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_ch,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic [31:0] o_value,
    output logic [3:0]  o_value_index,
    output logic [7:0]  o_keyword_start,
    output logic [7:0]  o_keyword_len,
    output logic [7:0]  o_option_start,
    output logic [7:0]  o_rest_start,
    output logic [4:0]  o_value_count,
    output logic        o_pipe_mode,
    output logic [1:0]  o_end_reason,
    output logic        o_last
);
    import clt_pkg::*;

    `include "command_line_tokenizer_top_assert.svh"

    localparam int VTW     = $clog2(MAX_VALUES + 1);
    localparam int VB      = VALUE_BITS;
    localparam int POS_MAX = ((MAX_CMD_LEN - 1) > 255) ? 255 : (MAX_CMD_LEN - 1);
    localparam logic [1:0] Q_LAST = 2'd2;

    // Configuration registers.
    logic [7:0] r_sep, r_comment, r_opt_sign;

    // Parse state.
    t_phase         r_phase, n_phase;
    logic [7:0]     r_pos, n_pos;
    logic [7:0]     r_kw_off, n_kw_off;
    logic [7:0]     r_kw_len, n_kw_len;
    logic [7:0]     r_opt_off, n_opt_off;
    logic [7:0]     r_rest_off, n_rest_off;
    logic [VTW-1:0] r_values_taken, n_values_taken;
    logic [VB-1:0]  r_dec, n_dec;
    logic [VB-1:0]  r_hex, n_hex;
    t_tok_status    r_tok, n_tok;
    logic           r_pipe, n_pipe;
    logic           r_comment_flag, n_comment_flag;

    // Result queue.
    t_result    r_q [3];
    logic [1:0] r_rd_ptr, r_wr_ptr, r_count;

    logic in_acc, pop;

    // Character classes.
    logic        line_end, ws, is_digit, is_x;
    logic [4:0]  hexd;
    logic [7:0]  sep_char;
    t_end_reason end_reason;

    // Token evaluation.
    logic          tok_ok;
    logic [VB-1:0] tok_val;
    t_tok_status   begin_tok, feed_tok;
    logic [VB-1:0] begin_dec, begin_hex, feed_dec, feed_hex;
    logic [VB+3:0] dec_ext, dec_prod;
    logic          dec_ovf;

    logic           emit_val, emit_sum, do_clear;
    logic [VTW-1:0] sum_vals;
    logic [1:0]     push_n;
    t_result        res0, res1, val_res, sum_res;

    function automatic logic [1:0] q_inc(input logic [1:0] p);
        return (p == Q_LAST) ? 2'd0 : p + 2'd1;
    endfunction

    assign o_in_ready  = (r_count <= 2'd1);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = (r_count != 2'd0);
    assign pop         = o_out_valid && i_out_ready;

    always_comb begin
        line_end = (i_ch == CH_NUL) || (i_ch == CH_CR) || (i_ch == CH_LF);
        ws       = (i_ch == CH_SPACE) || (i_ch == CH_TAB);
        is_digit = (i_ch >= CH_0) && (i_ch <= CH_9);
        is_x     = (i_ch == CH_LO_X) || (i_ch == CH_UP_X);
        hexd     = hex_digit(i_ch);
        sep_char = r_pipe ? CH_PIPE_SEP : r_sep;
        if (i_ch == sep_char) begin
            end_reason = END_SEP;
        end else if (i_ch == r_comment) begin
            end_reason = END_COMMENT;
        end else if (line_end) begin
            end_reason = END_LINE;
        end else begin
            end_reason = END_NONE;
        end
    end

    // Value of the open token if it closes now.
    always_comb begin
        tok_ok = (r_tok.x2 ? r_tok.hok : r_tok.dok) &&
                 (r_values_taken < VTW'(MAX_VALUES));
        if (r_tok.x2) begin
            tok_val = r_hex;
        end else if (r_tok.dneg) begin
            tok_val = '0 - r_dec;
        end else begin
            tok_val = r_dec;
        end
    end

    // First character of a value token.
    always_comb begin
        begin_tok = '0;
        begin_dec = '0;
        begin_hex = '0;
        if (i_ch == CH_DOLLAR) begin
            begin_tok.dok = 1'b1;
            begin_tok.hok = 1'b1;
        end else begin
            if (i_ch == CH_PLUS) begin
                begin_tok.drun = 1'b1;
            end else if (i_ch == CH_MINUS) begin
                begin_tok.drun = 1'b1;
                begin_tok.dneg = 1'b1;
            end else if (is_digit) begin
                begin_dec      = VB'(i_ch[3:0]);
                begin_tok.drun = 1'b1;
                begin_tok.dok  = 1'b1;
            end
            if (hexd[4]) begin
                begin_hex      = VB'(hexd[3:0]);
                begin_tok.hok  = 1'b1;
                begin_tok.hrun = 1'b1;
            end
        end
    end

    // Later characters of a value token: decimal and hex run side by side.
    always_comb begin
        dec_ext  = {4'b0, r_dec};
        dec_prod = (dec_ext << 3) + (dec_ext << 1) + (VB + 4)'(i_ch[3:0]);
        dec_ovf  = |dec_prod[VB+3:VB];
        feed_tok = r_tok;
        feed_dec = r_dec;
        feed_hex = r_hex;
        if (r_tok.drun) begin
            if (is_digit) begin
                if (dec_ovf) begin
                    feed_dec      = '1;
                    feed_tok.drun = 1'b0;
                    feed_tok.dneg = 1'b0;
                end else begin
                    feed_dec = dec_prod[VB-1:0];
                end
                feed_tok.dok = 1'b1;
            end else begin
                feed_tok.drun = 1'b0;
            end
        end
        if (!r_tok.seen2) begin
            // The second character decides between hex and decimal form.
            feed_tok.seen2 = 1'b1;
            if (is_x) begin
                feed_tok.x2 = 1'b1;
            end
            if (!(is_x && (r_hex == '0))) begin
                feed_tok.hrun = 1'b0;
            end
        end else if (r_tok.hrun) begin
            if (hexd[4]) begin
                if (|r_hex[VB-1:VB-4]) begin
                    feed_hex      = '1;
                    feed_tok.hrun = 1'b0;
                end else begin
                    feed_hex = {r_hex[VB-5:0], hexd[3:0]};
                end
            end else begin
                feed_tok.hrun = 1'b0;
            end
        end
    end

    // Next parse state.
    always_comb begin
        n_phase        = r_phase;
        n_pos          = r_pos;
        n_kw_off       = r_kw_off;
        n_kw_len       = r_kw_len;
        n_opt_off      = r_opt_off;
        n_rest_off     = r_rest_off;
        n_values_taken = r_values_taken;
        n_dec          = r_dec;
        n_hex          = r_hex;
        n_tok          = r_tok;
        n_pipe         = r_pipe;
        n_comment_flag = r_comment_flag;
        emit_val       = 1'b0;
        emit_sum       = 1'b0;
        do_clear       = 1'b0;
        if (r_comment_flag) begin
            if (line_end) begin
                do_clear       = 1'b1;
                n_comment_flag = 1'b0;
            end
        end else if ((r_phase == PH_START) && (i_ch == CH_PIPE)) begin
            n_pipe  = 1'b1;
            n_phase = PH_SEEK_KW;
        end else if (end_reason != END_NONE) begin
            emit_val       = (r_phase == PH_VALUE) && tok_ok;
            emit_sum       = 1'b1;
            do_clear       = 1'b1;
            n_comment_flag = (end_reason == END_COMMENT) ||
                             ((end_reason == END_SEP) && r_pipe);
        end else begin
            case (r_phase)
                PH_START, PH_SEEK_KW: begin
                    if (!ws) begin
                        n_kw_off = r_pos;
                        n_kw_len = 8'd1;
                        n_phase  = PH_KEYWORD;
                    end else begin
                        // Any character leaves the command start, so a later '|' is plain text.
                        n_phase = PH_SEEK_KW;
                    end
                end
                PH_KEYWORD: begin
                    if (ws) begin
                        n_phase = PH_SEEK_OPT;
                    end else if (r_kw_len < 8'hFF) begin
                        n_kw_len = r_kw_len + 8'd1;
                    end
                end
                PH_SEEK_OPT, PH_SEEK_VAL: begin
                    if (!ws) begin
                        if ((r_phase == PH_SEEK_OPT) && (i_ch == r_opt_sign)) begin
                            n_opt_off = r_pos;
                            n_phase   = PH_OPTION;
                        end else begin
                            if ((r_values_taken == '0) && (r_rest_off == 8'd0)) begin
                                n_rest_off = r_pos;
                            end
                            n_tok   = begin_tok;
                            n_dec   = begin_dec;
                            n_hex   = begin_hex;
                            n_phase = PH_VALUE;
                        end
                    end
                end
                PH_OPTION: begin
                    if (ws) begin
                        n_phase = PH_SEEK_VAL;
                    end
                end
                default: begin
                    if (ws) begin
                        emit_val       = tok_ok;
                        n_values_taken = r_values_taken + VTW'(tok_ok);
                        n_tok          = '0;
                        n_phase        = PH_SEEK_VAL;
                    end else begin
                        n_tok = feed_tok;
                        n_dec = feed_dec;
                        n_hex = feed_hex;
                    end
                end
            endcase
            if (r_pos < 8'(POS_MAX)) begin
                n_pos = r_pos + 8'd1;
            end
        end
        if (do_clear) begin
            n_phase        = PH_START;
            n_pos          = '0;
            n_kw_off       = '0;
            n_kw_len       = '0;
            n_opt_off      = '0;
            n_rest_off     = '0;
            n_values_taken = '0;
            n_dec          = '0;
            n_hex          = '0;
            n_tok          = '0;
            n_pipe         = 1'b0;
        end
    end

    // Result items of this character.
    always_comb begin
        sum_vals = r_values_taken + VTW'(emit_val);

        val_res             = '0;
        val_res.kind        = KIND_VALUE;
        val_res.value       = 32'(tok_val);
        val_res.value_index = 4'(r_values_taken);
        val_res.last        = !emit_sum;

        sum_res               = '0;
        sum_res.kind          = KIND_SUMMARY;
        sum_res.keyword_start = (r_kw_len != 8'd0) ? r_kw_off : 8'd0;
        sum_res.keyword_len   = r_kw_len;
        sum_res.option_start  = r_opt_off;
        sum_res.rest_start    = r_rest_off;
        sum_res.value_count   = 5'(sum_vals);
        sum_res.pipe_mode     = r_pipe;
        sum_res.end_reason    = end_reason;
        sum_res.last          = 1'b1;

        res0   = emit_val ? val_res : sum_res;
        res1   = sum_res;
        push_n = in_acc ? (2'(emit_val) + 2'(emit_sum)) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep      <= SEP_RESET;
            r_comment  <= COMMENT_RESET;
            r_opt_sign <= OPTION_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SEPARATOR:   r_sep      <= i_cfg_data;
                CFG_COMMENT:     r_comment  <= i_cfg_data;
                CFG_OPTION_SIGN: r_opt_sign <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_START;
            r_pos          <= '0;
            r_kw_off       <= '0;
            r_kw_len       <= '0;
            r_opt_off      <= '0;
            r_rest_off     <= '0;
            r_values_taken <= '0;
            r_dec          <= '0;
            r_hex          <= '0;
            r_tok          <= '0;
            r_pipe         <= 1'b0;
            r_comment_flag <= 1'b0;
        end else if (in_acc) begin
            r_phase        <= n_phase;
            r_pos          <= n_pos;
            r_kw_off       <= n_kw_off;
            r_kw_len       <= n_kw_len;
            r_opt_off      <= n_opt_off;
            r_rest_off     <= n_rest_off;
            r_values_taken <= n_values_taken;
            r_dec          <= n_dec;
            r_hex          <= n_hex;
            r_tok          <= n_tok;
            r_pipe         <= n_pipe;
            r_comment_flag <= n_comment_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_q[r_wr_ptr] <= res0;
        end
        if (push_n == 2'd2) begin
            r_q[q_inc(r_wr_ptr)] <= res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (pop) begin
                r_rd_ptr <= q_inc(r_rd_ptr);
            end
            case (push_n)
                2'd1:    r_wr_ptr <= q_inc(r_wr_ptr);
                2'd2:    r_wr_ptr <= q_inc(q_inc(r_wr_ptr));
                default: r_wr_ptr <= r_wr_ptr;
            endcase
            r_count <= r_count + push_n - 2'(pop);
        end
    end

    assign o_kind          = r_q[r_rd_ptr].kind;
    assign o_value         = r_q[r_rd_ptr].value;
    assign o_value_index   = r_q[r_rd_ptr].value_index;
    assign o_keyword_start = r_q[r_rd_ptr].keyword_start;
    assign o_keyword_len   = r_q[r_rd_ptr].keyword_len;
    assign o_option_start  = r_q[r_rd_ptr].option_start;
    assign o_rest_start    = r_q[r_rd_ptr].rest_start;
    assign o_value_count   = r_q[r_rd_ptr].value_count;
    assign o_pipe_mode     = r_q[r_rd_ptr].pipe_mode;
    assign o_end_reason    = r_q[r_rd_ptr].end_reason;
    assign o_last          = r_q[r_rd_ptr].last;

    // The queue pointers meet only when it is empty or full.
    `CLT_ASSERT_ALWAYS(a_queue_ptrs, i_clk, i_rst_n,
        ((r_count == 2'd0) || (r_count == 2'd3)) == (r_wr_ptr == r_rd_ptr),
        "result queue pointers disagree with the fill count")

    // A value result that is not last is always followed by its summary.
    `CLT_ASSERT_NEXT(a_pair_follows, i_clk, i_rst_n, pop && !o_last,
        o_out_valid && (o_kind == KIND_SUMMARY), "summary missing after value result")

    // A summary leaves the parser at the start of a fresh command.
    `CLT_ASSERT_NEXT(a_cmd_cleared, i_clk, i_rst_n, in_acc && emit_sum,
        (r_phase == PH_START) && (r_pos == 8'd0) && (r_values_taken == '0),
        "command state not cleared after summary")

endmodule

`default_nettype wire

/* bench/command_line_tokenizer_top_tb.sv */
// Self-checking testbench for the command line tokenizer: directed and random character streams.
`timescale 1ns / 1ps

module command_line_tokenizer_top_tb;
    import clt_pkg::*;

    localparam int          MAX_VALUES    = 16;
    localparam int          MAX_CMD_LEN   = 256;
    localparam int          VALUE_BITS    = 32;
    localparam logic [31:0] VALUE_MAX     = 32'hFFFF_FFFF;
    localparam logic [7:0]  POSITION_MAX  = 8'd255;
    localparam logic [1:0]  CFG_BAD_INDEX = 2'd3;
    localparam int          IDLE_MAX      = 14;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          PHASE_CHARS   = 150;
    localparam int          NUM_PHASES    = 6;
    localparam int          CYCLE_LIMIT   = 500000;
    localparam string       DIGITS        = "0123456789";
    localparam string       HEX_DIGITS    = "0123456789abcdefABCDEF";
    localparam string       LETTERS       = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";

    class tokenizer_scoreboard;
        logic [7:0]  sep_char;
        logic [7:0]  comment_char;
        logic [7:0]  option_char;
        t_phase      phase;
        logic [7:0]  pos;
        logic [7:0]  kw_off;
        logic [7:0]  kw_len;
        logic [7:0]  opt_off;
        logic [7:0]  rest_off;
        logic [4:0]  n_values;
        logic [31:0] dec_acc;
        logic [31:0] hex_acc;
        t_tok_status tok;
        bit          pipe;
        bit          in_comment;
        t_result     pending_results[$];
        int          error_count;

        function new();
            sep_char     = SEP_RESET;
            comment_char = COMMENT_RESET;
            option_char  = OPTION_RESET;
            clear_command();
            in_comment  = 1'b0;
            error_count = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [7:0] data);
            case (idx)
                CFG_SEPARATOR:   sep_char = data;
                CFG_COMMENT:     comment_char = data;
                CFG_OPTION_SIGN: option_char = data;
                default: ;
            endcase
        endfunction

        function void clear_command();
            phase    = PH_START;
            pos      = '0;
            kw_off   = '0;
            kw_len   = '0;
            opt_off  = '0;
            rest_off = '0;
            n_values = '0;
            dec_acc  = '0;
            hex_acc  = '0;
            tok      = '0;
            pipe     = 1'b0;
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CH_0 && c <= CH_9;
        endfunction

        function bit hex_char(logic [7:0] c, output logic [3:0] v);
            v = '0;
            if (is_digit(c)) begin
                v = 4'(c - CH_0);
                return 1'b1;
            end
            if (c >= CH_LO_A && c <= CH_LO_F) begin
                v = 4'(c - CH_LO_A + 8'd10);
                return 1'b1;
            end
            if (c >= CH_UP_A && c <= CH_UP_F) begin
                v = 4'(c - CH_UP_A + 8'd10);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void open_token(logic [7:0] c);
            logic [3:0] hv;
            bit         is_hex;
            is_hex = hex_char(c, hv);
            if (n_values == 0 && rest_off == 0) rest_off = pos;
            tok     = '0;
            dec_acc = '0;
            hex_acc = '0;
            if (c == CH_DOLLAR) begin
                tok.dok = 1'b1;
                tok.hok = 1'b1;
                return;
            end
            if (c == CH_PLUS) begin
                tok.drun = 1'b1;
            end else if (c == CH_MINUS) begin
                tok.drun = 1'b1;
                tok.dneg = 1'b1;
            end else if (is_digit(c)) begin
                dec_acc  = {24'd0, c} - {24'd0, CH_0};
                tok.drun = 1'b1;
                tok.dok  = 1'b1;
            end
            if (is_hex) begin
                hex_acc  = {28'd0, hv};
                tok.hok  = 1'b1;
                tok.hrun = 1'b1;
            end
        endfunction

        function void feed_token(logic [7:0] c);
            logic [3:0]  hv;
            logic [31:0] d;
            bit          is_hex;
            bit          is_x;
            is_hex = hex_char(c, hv);
            is_x   = (c == CH_LO_X || c == CH_UP_X);
            d      = {24'd0, c} - {24'd0, CH_0};
            if (tok.drun) begin
                if (is_digit(c)) begin
                    // Saturation also drops the sign.
                    if (dec_acc > (VALUE_MAX - d) / 32'd10) begin
                        dec_acc  = VALUE_MAX;
                        tok.drun = 1'b0;
                        tok.dneg = 1'b0;
                    end else begin
                        dec_acc = dec_acc * 32'd10 + d;
                    end
                    tok.dok = 1'b1;
                end else begin
                    tok.drun = 1'b0;
                end
            end
            // The second character decides between hex and decimal form.
            if (!tok.seen2) begin
                tok.seen2 = 1'b1;
                if (is_x) tok.x2 = 1'b1;
                if (!(is_x && hex_acc == 0)) tok.hrun = 1'b0;
                return;
            end
            if (tok.hrun) begin
                if (is_hex) begin
                    if (hex_acc > (VALUE_MAX >> 4)) begin
                        hex_acc  = VALUE_MAX;
                        tok.hrun = 1'b0;
                    end else begin
                        hex_acc = {hex_acc[27:0], hv};
                    end
                end else begin
                    tok.hrun = 1'b0;
                end
            end
        endfunction

        function void close_token(bit is_last);
            t_result r;
            bit      ok;
            bit      as_hex;
            if (!tok.x2 && tok.dneg) dec_acc = 32'd0 - dec_acc;
            as_hex = tok.x2;
            ok     = as_hex ? tok.hok : tok.dok;
            tok    = '0;
            if (!ok || n_values >= MAX_VALUES) return;
            r             = '0;
            r.kind        = KIND_VALUE;
            r.value       = as_hex ? hex_acc : dec_acc;
            r.value_index = n_values[3:0];
            r.last        = is_last;
            n_values++;
            pending_results.push_back(r);
        endfunction

        function void tokenize_char(logic [7:0] c);
            bit          at_line_end;
            bit          blank;
            bit          was_pipe;
            logic [7:0]  sep;
            t_end_reason why;
            t_result     r;
            at_line_end = (c == CH_NUL || c == CH_CR || c == CH_LF);
            blank       = (c == CH_SPACE || c == CH_TAB);
            if (in_comment) begin
                if (at_line_end) begin
                    clear_command();
                    in_comment = 1'b0;
                end
                return;
            end
            if (phase == PH_START && c == CH_PIPE) begin
                pipe  = 1'b1;
                phase = PH_SEEK_KW;
                return;
            end
            sep = pipe ? CH_PIPE_SEP : sep_char;
            why = END_NONE;
            if (c == sep) why = END_SEP;
            else if (c == comment_char) why = END_COMMENT;
            else if (at_line_end) why = END_LINE;
            if (why != END_NONE) begin
                if (phase == PH_VALUE) close_token(1'b0);
                r               = '0;
                r.kind          = KIND_SUMMARY;
                r.keyword_start = (kw_len != 0) ? kw_off : 8'd0;
                r.keyword_len   = kw_len;
                r.option_start  = opt_off;
                r.rest_start    = rest_off;
                r.value_count   = n_values;
                r.pipe_mode     = pipe;
                r.end_reason    = why;
                r.last          = 1'b1;
                pending_results.push_back(r);
                was_pipe = pipe;
                clear_command();
                // A pipe command's separator discards the rest of its line.
                if (why == END_COMMENT || (why == END_SEP && was_pipe)) in_comment = 1'b1;
                return;
            end
            if (phase == PH_START) phase = PH_SEEK_KW;
            case (phase)
                PH_SEEK_KW: begin
                    if (!blank) begin
                        kw_off = pos;
                        kw_len = 8'd1;
                        phase  = PH_KEYWORD;
                    end
                end
                PH_KEYWORD: begin
                    if (blank) phase = PH_SEEK_OPT;
                    else if (kw_len < 8'd255) kw_len++;
                end
                PH_SEEK_OPT: begin
                    if (!blank) begin
                        if (c == option_char) begin
                            opt_off = pos;
                            phase   = PH_OPTION;
                        end else begin
                            open_token(c);
                            phase = PH_VALUE;
                        end
                    end
                end
                PH_OPTION: begin
                    if (blank) phase = PH_SEEK_VAL;
                end
                PH_SEEK_VAL: begin
                    if (!blank) begin
                        open_token(c);
                        phase = PH_VALUE;
                    end
                end
                default: begin
                    if (blank) begin
                        close_token(1'b1);
                        phase = PH_SEEK_VAL;
                    end else begin
                        feed_token(c);
                    end
                end
            endcase
            if (pos < POSITION_MAX) pos++;
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] seen);
            if (want !== seen) begin
                $error("%s: expected %0h, got %0h", name, want, seen);
                error_count++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: kind %0d value %0h", got.kind, got.value);
                error_count++;
                return;
            end
            want = pending_results.pop_front();
            check_field("kind", want.kind, got.kind);
            check_field("value", want.value, got.value);
            check_field("value_index", want.value_index, got.value_index);
            check_field("keyword_start", want.keyword_start, got.keyword_start);
            check_field("keyword_len", want.keyword_len, got.keyword_len);
            check_field("option_start", want.option_start, got.option_start);
            check_field("rest_start", want.rest_start, got.rest_start);
            check_field("value_count", want.value_count, got.value_count);
            check_field("pipe_mode", want.pipe_mode, got.pipe_mode);
            check_field("end_reason", want.end_reason, got.end_reason);
            check_field("last", want.last, got.last);
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_ch        = '0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_kind;
    logic [31:0] o_value;
    logic [3:0]  o_value_index;
    logic [7:0]  o_keyword_start;
    logic [7:0]  o_keyword_len;
    logic [7:0]  o_option_start;
    logic [7:0]  o_rest_start;
    logic [4:0]  o_value_count;
    logic        o_pipe_mode;
    logic [1:0]  o_end_reason;
    logic        o_last;

    tokenizer_scoreboard sb = new();
    logic [7:0] cmd_chars[$];
    int         in_gap_max  = IDLE_MAX;
    int         out_gap_max = IDLE_MAX;
    int         out_stall   = 0;
    int         cycle_count = 0;
    int         phase_chars;

    command_line_tokenizer_top #(
        .MAX_VALUES (MAX_VALUES),
        .MAX_CMD_LEN(MAX_CMD_LEN),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_ch           (i_ch),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_value        (o_value),
        .o_value_index  (o_value_index),
        .o_keyword_start(o_keyword_start),
        .o_keyword_len  (o_keyword_len),
        .o_option_start (o_option_start),
        .o_rest_start   (o_rest_start),
        .o_value_count  (o_value_count),
        .o_pipe_mode    (o_pipe_mode),
        .o_end_reason   (o_end_reason),
        .o_last         (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: check each accepted transaction, then draw the next stall.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.kind          = o_kind;
            got.value         = o_value;
            got.value_index   = o_value_index;
            got.keyword_start = o_keyword_start;
            got.keyword_len   = o_keyword_len;
            got.option_start  = o_option_start;
            got.rest_start    = o_rest_start;
            got.value_count   = o_value_count;
            got.pipe_mode     = o_pipe_mode;
            got.end_reason    = o_end_reason;
            got.last          = o_last;
            sb.check_result(got);
            out_stall = $urandom_range(0, out_gap_max);
        end
    end

    always @(negedge i_clk) begin
        if (out_stall > 0) begin
            i_out_ready <= 1'b0;
            out_stall--;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic logic [7:0] pick(string charset);
        return charset[$urandom_range(0, charset.len() - 1)];
    endfunction

    function automatic logic [7:0] pick_blank();
        return ($urandom_range(0, 3) == 0) ? CH_TAB : CH_SPACE;
    endfunction

    function automatic logic [7:0] pick_line_end();
        case ($urandom_range(0, 2))
            0:       return CH_NUL;
            1:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic void add_chars(int n, string charset);
        repeat (n) cmd_chars.push_back(pick(charset));
    endfunction

    function automatic void add_discarded_tail();
        add_chars($urandom_range(0, 4), LETTERS);
        cmd_chars.push_back(pick_line_end());
    endfunction

    function automatic void add_value_token();
        case ($urandom_range(0, 9))
            0: add_chars($urandom_range(1, 3), DIGITS);
            1: add_chars($urandom_range(9, 12), DIGITS);
            2: begin
                cmd_chars.push_back(pick("+-"));
                add_chars($urandom_range(1, 11), DIGITS);
            end
            3: begin
                cmd_chars.push_back(CH_0);
                cmd_chars.push_back(pick("xX"));
                add_chars($urandom_range(0, 9), HEX_DIGITS);
            end
            4: begin
                cmd_chars.push_back(CH_DOLLAR);
                if ($urandom_range(0, 2) == 0) add_chars($urandom_range(1, 2), "xX5");
            end
            5: begin
                cmd_chars.push_back(pick("123456789abcdefABCDEF"));
                cmd_chars.push_back(pick("xX"));
                add_chars($urandom_range(0, 4), HEX_DIGITS);
            end
            6: begin
                add_chars($urandom_range(1, 4), DIGITS);
                add_chars($urandom_range(1, 3), LETTERS);
            end
            7: add_chars($urandom_range(1, 3), LETTERS);
            8: begin
                cmd_chars.push_back(pick("+-"));
                cmd_chars.push_back(pick("xX"));
                add_chars($urandom_range(0, 3), HEX_DIGITS);
            end
            default: repeat ($urandom_range(1, 3)) cmd_chars.push_back(8'($urandom_range(33, 126)));
        endcase
    endfunction

    // Mostly well-formed commands with random content; some raw byte noise.
    function automatic void build_command(bit long_keyword);
        bit piped;
        int n_vals;
        cmd_chars.delete();
        if (!long_keyword && $urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 10)) cmd_chars.push_back(8'($urandom_range(0, 255)));
            return;
        end
        piped = ($urandom_range(0, 5) == 0);
        if (piped) cmd_chars.push_back(CH_PIPE);
        if ($urandom_range(0, 3) == 0) cmd_chars.push_back(pick_blank());
        if (long_keyword || $urandom_range(0, 11) != 0) begin
            add_chars(long_keyword ? $urandom_range(258, 262) : $urandom_range(1, 6), LETTERS);
            if ($urandom_range(0, 1) == 1) begin
                cmd_chars.push_back(pick_blank());
                cmd_chars.push_back(sb.option_char);
                add_chars($urandom_range(0, 3), LETTERS);
            end
            n_vals = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 19) : $urandom_range(0, 4);
            repeat (n_vals) begin
                cmd_chars.push_back(pick_blank());
                if ($urandom_range(0, 3) == 0) cmd_chars.push_back(pick_blank());
                add_value_token();
            end
            if ($urandom_range(0, 4) == 0) cmd_chars.push_back(pick_blank());
        end
        case ($urandom_range(0, 3))
            0: begin
                cmd_chars.push_back(piped ? CH_PIPE_SEP : sb.sep_char);
                if (piped) add_discarded_tail();
            end
            1: begin
                cmd_chars.push_back(sb.comment_char);
                add_discarded_tail();
            end
            default: cmd_chars.push_back(pick_line_end());
        endcase
    endfunction

    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_ch       <= c;
        do @(posedge i_clk); while (!o_in_ready);
        sb.tokenize_char(c);
    endtask

    task automatic send_string(input string s);
        for (int k = 0; k < s.len(); k++) send_char(s[k]);
    endtask

    task automatic send_command();
        foreach (cmd_chars[k]) send_char(cmd_chars[k]);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        sb.set_register(idx, data);
    endtask

    task automatic configure(input logic [7:0] sep, input logic [7:0] com,
                             input logic [7:0] opt);
        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        write_reg(CFG_SEPARATOR, sep);
        write_reg(CFG_COMMENT, com);
        write_reg(CFG_OPTION_SIGN, opt);
        write_reg(CFG_BAD_INDEX, 8'($urandom_range(0, 255)));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Option, empty hex, negative decimal, digit before x, two results at the separator.
        send_string("k -o 0x -9 4x7;");
        // Pipe command closed by a comment; the line end is swallowed.
        send_string("|#");
        send_char(CH_LF);
        // Empty command.
        send_string(";");
        // Pipe separator discards the rest of the line.
        send_string("|z 1");
        send_char(CH_PIPE_SEP);
        send_string("x");
        send_char(CH_NUL);
        // A blank before '|' makes it part of the keyword, not a pipe command.
        send_string(" |k 5;");

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: configure(SEP_RESET, COMMENT_RESET, OPTION_RESET);
                1: configure(8'h00, 8'hFF, 8'h00);
                2: configure(8'hFF, 8'h00, 8'hFF);
                3: configure(8'h2C, 8'h21, 8'h2F);
                4: configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)));
                default: configure(SEP_RESET, COMMENT_RESET, OPTION_RESET);
            endcase
            phase_chars = 0;
            while (phase_chars < PHASE_CHARS) begin
                if (p == NUM_PHASES - 1) begin
                    // No idling on either side, and each command waits for the last one's results.
                    drain();
                    in_gap_max  = 0;
                    out_gap_max = 0;
                end else begin
                    in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
                    out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
                end
                build_command(p == 0 && phase_chars == 0);
                send_command();
                phase_chars += cmd_chars.size();
            end
            send_char(CH_LF);
        end

        drain();
        repeat (SETTLE_CYCLES * 4) @(posedge i_clk);
        if (sb.error_count == 0 && sb.pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* command_line_tokenizer_top.f */
+incdir+rtl/core
rtl/core/clt_pkg.sv
rtl/core/command_line_tokenizer_top.sv
bench/command_line_tokenizer_top_tb.sv
